// ===== rtl/tmhq_pkg.sv =====
// ---------------------------------------------------------------------------
// tmhq_pkg
// Shared types and codes for the timer min-heap queue: request and response
// payloads, opcodes, controller states and the command/status buses.
// ---------------------------------------------------------------------------
package tmhq_pkg;

   // opcodes
   localparam logic [1:0] OP_ARM    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_POLL   = 2'd2;

   // request payload
   typedef struct packed {
      logic [1:0]         opcode;
      logic [4:0]         timer_id;
      logic signed [31:0] delay;
      logic [47:0]        now_ms;
   } req_type;

   // response payload
   typedef struct packed {
      logic        fired_valid;
      logic [4:0]  fired_timer;
      logic [47:0] earliest_due;
      logic        heap_empty;
      logic [5:0]  armed_count;
      logic        last_of_run;
   } rsp_type;

   // slot memory read address select
   typedef enum logic [1:0] {
      RD_LAST,
      RD_CHILD,
      RD_PARENT
   } rd_sel_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CAN_CHK,
      ST_LOAD,
      ST_SD_RD,
      ST_SD_CMP,
      ST_SU_RD,
      ST_SU_CMP,
      ST_APPEND,
      ST_POLL_CHK,
      ST_EMIT_FIRE,
      ST_EMIT_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       clear_req;
      logic       cancel_go;
      logic       pop_go;
      rd_sel_type rd_sel;
      logic       load_carried;
      logic       sd_cmp;
      logic       su_cmp;
      logic       place;
      logic       append;
      logic       emit_fire;
      logic       emit_done;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_arm;
      logic op_cancel;
      logic op_poll;
      logic id_ok;
      logic pos_armed;
      logic hole_last;
      logic pop_due;
      logic pop_last;
      logic sd_move;
      logic s_at_start;
      logic s_zero;
      logic su_stop;
      logic full;
   } status_type;

endpackage

// ===== rtl/tmhq_ctrl.sv =====
// ---------------------------------------------------------------------------
// tmhq_ctrl
// Sequencer for arm, cancel and poll: walks the heap sift loops one level
// at a time through read and compare states and schedules the response strobes.
// ---------------------------------------------------------------------------
module tmhq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tmhq_pkg::status_type status,
   output tmhq_pkg::cmd_type    cmd
);

   tmhq_pkg::state_type state_ff, state_in;
   logic                appended_ff, appended_in;
   tmhq_pkg::state_type route;

   // where to go once a heap update has settled
   always_comb begin
      if (status.op_poll) begin
         route = tmhq_pkg::ST_EMIT_FIRE;
      end else if (status.op_arm && !appended_ff) begin
         route = tmhq_pkg::ST_APPEND;
      end else begin
         route = tmhq_pkg::ST_EMIT_DONE;
      end
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      appended_in = appended_ff;
      case (state_ff)
         tmhq_pkg::ST_IDLE: begin
            if (start) begin
               state_in    = tmhq_pkg::ST_DECODE;
               appended_in = 1'b0;
            end
         end
         tmhq_pkg::ST_DECODE: begin
            if (status.op_poll) begin
               state_in = tmhq_pkg::ST_POLL_CHK;
            end else if ((status.op_arm || status.op_cancel) && status.id_ok) begin
               state_in = tmhq_pkg::ST_CAN_CHK;
            end else begin
               state_in = tmhq_pkg::ST_EMIT_DONE;
            end
         end
         tmhq_pkg::ST_CAN_CHK: begin
            if (status.pos_armed && !status.hole_last) begin
               state_in = tmhq_pkg::ST_LOAD;
            end else begin
               state_in = route;
            end
         end
         tmhq_pkg::ST_LOAD:   state_in = tmhq_pkg::ST_SD_RD;
         tmhq_pkg::ST_SD_RD:  state_in = tmhq_pkg::ST_SD_CMP;
         tmhq_pkg::ST_SD_CMP: begin
            if (status.sd_move) begin
               state_in = tmhq_pkg::ST_SD_RD;
            end else if (status.s_at_start) begin
               state_in = tmhq_pkg::ST_SU_RD;
            end else begin
               state_in = route;
            end
         end
         tmhq_pkg::ST_SU_RD: begin
            if (status.s_zero) begin
               state_in = route;
            end else begin
               state_in = tmhq_pkg::ST_SU_CMP;
            end
         end
         tmhq_pkg::ST_SU_CMP: begin
            if (status.su_stop) begin
               state_in = route;
            end else begin
               state_in = tmhq_pkg::ST_SU_RD;
            end
         end
         tmhq_pkg::ST_APPEND: begin
            appended_in = 1'b1;
            if (status.full) begin
               state_in = tmhq_pkg::ST_EMIT_DONE;
            end else begin
               state_in = tmhq_pkg::ST_SU_RD;
            end
         end
         tmhq_pkg::ST_POLL_CHK: begin
            if (!status.pop_due) begin
               state_in = tmhq_pkg::ST_EMIT_DONE;
            end else if (status.pop_last) begin
               state_in = tmhq_pkg::ST_EMIT_FIRE;
            end else begin
               state_in = tmhq_pkg::ST_LOAD;
            end
         end
         tmhq_pkg::ST_EMIT_FIRE: state_in = tmhq_pkg::ST_POLL_CHK;
         tmhq_pkg::ST_EMIT_DONE: state_in = tmhq_pkg::ST_IDLE;
         default:                state_in = tmhq_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = tmhq_pkg::RD_LAST;
      case (state_ff)
         tmhq_pkg::ST_IDLE:   cmd.capture = start;
         tmhq_pkg::ST_CAN_CHK: begin
            cmd.clear_req = 1'b1;
            cmd.cancel_go = status.pos_armed;
         end
         tmhq_pkg::ST_LOAD:   cmd.load_carried = 1'b1;
         tmhq_pkg::ST_SD_RD:  cmd.rd_sel = tmhq_pkg::RD_CHILD;
         tmhq_pkg::ST_SD_CMP: cmd.sd_cmp = 1'b1;
         tmhq_pkg::ST_SU_RD: begin
            cmd.rd_sel = tmhq_pkg::RD_PARENT;
            cmd.place  = status.s_zero;
         end
         tmhq_pkg::ST_SU_CMP:    cmd.su_cmp = 1'b1;
         tmhq_pkg::ST_APPEND:    cmd.append = 1'b1;
         tmhq_pkg::ST_POLL_CHK:  cmd.pop_go = status.pop_due;
         tmhq_pkg::ST_EMIT_FIRE: cmd.emit_fire = 1'b1;
         tmhq_pkg::ST_EMIT_DONE: cmd.emit_done = 1'b1;
         default:                cmd.capture = 1'b0;
      endcase
   end

   assign busy = (state_ff != tmhq_pkg::ST_IDLE);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tmhq_pkg::ST_IDLE;
         appended_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         appended_ff <= appended_in;
      end
   end

endmodule

// ===== rtl/tmhq_dpath.sv =====
// ---------------------------------------------------------------------------
// tmhq_dpath
// Heap storage and arithmetic: slot memory with two registered read ports,
// per-timer position memory with valid bits, the carried element of a sift,
// heap length, a copy of the heap top and the response register.
// ---------------------------------------------------------------------------
module tmhq_dpath #(
   parameter int NUM_TIMERS = 32,
   parameter int TIME_BITS  = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tmhq_pkg::req_type    req_data,
   input  tmhq_pkg::cmd_type    cmd,
   output tmhq_pkg::status_type status,
   output logic                 rsp_valid,
   output tmhq_pkg::rsp_type    rsp_data
);

   localparam int IW = $clog2(NUM_TIMERS);
   localparam int PW = $clog2(NUM_TIMERS + 1);
   localparam int CW = IW + 2;
   localparam int SW = ((TIME_BITS > 31) ? TIME_BITS : 31) + 1;

   // storage
   logic [IW-1:0]        id_mem  [NUM_TIMERS];
   logic [TIME_BITS-1:0] due_mem [NUM_TIMERS];
   logic [PW-1:0]        pos_mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] pos_vld_ff;

   // request and working registers
   tmhq_pkg::req_type    req_ff;
   logic [PW-1:0]        len_ff;
   logic [IW-1:0]        s_ff, start_ff;
   logic [IW-1:0]        cid_ff;
   logic [TIME_BITS-1:0] cdue_ff;
   logic [IW-1:0]        top_id_ff;
   logic [TIME_BITS-1:0] top_due_ff;
   logic [IW-1:0]        fired_ff;
   logic [IW-1:0]        rda_id_ff, rdb_id_ff;
   logic [TIME_BITS-1:0] rda_due_ff, rdb_due_ff;
   logic [PW-1:0]        pos_rd_ff;
   logic                 rsp_valid_ff;
   tmhq_pkg::rsp_type    rsp_ff;

   // derived request values
   logic [IW-1:0]        req_id;
   logic [TIME_BITS-1:0] now_t;
   logic [30:0]          delay_pos;
   logic [SW-1:0]        due_sum;
   logic [TIME_BITS-1:0] due_new;
   logic [PW-1:0]        len_dec;

   assign req_id    = IW'(req_ff.timer_id);
   assign now_t     = TIME_BITS'(req_ff.now_ms);
   assign delay_pos = req_ff.delay[31] ? 31'd0 : req_ff.delay[30:0];
   assign due_sum   = SW'(now_t) + SW'(delay_pos);
   assign due_new   = (due_sum[SW-1:TIME_BITS] != '0) ? '1 : due_sum[TIME_BITS-1:0];
   assign len_dec   = len_ff - PW'(1);

   // heap neighbors of the current slot
   logic [CW-1:0] l_idx, r_idx;
   logic [IW-1:0] p_idx;
   logic          l_ok, r_ok;

   assign l_idx = {1'b0, s_ff, 1'b1};
   assign r_idx = l_idx + CW'(1);
   assign p_idx = (s_ff - IW'(1)) >> 1;
   assign l_ok  = l_idx < CW'(len_ff);
   assign r_ok  = r_idx < CW'(len_ff);

   // sift-down child choice, left child first, strictly smaller only
   logic                 take_l, take_r, sd_move;
   logic [TIME_BITS-1:0] min_due;

   always_comb begin
      take_l  = l_ok && (rda_due_ff < cdue_ff);
      min_due = take_l ? rda_due_ff : cdue_ff;
      take_r  = r_ok && (rdb_due_ff < min_due);
      sd_move = take_l || take_r;
   end

   logic su_stop;
   assign su_stop = rda_due_ff <= cdue_ff;

   // read addresses
   logic [IW-1:0] ra_addr, rb_addr;

   always_comb begin
      case (cmd.rd_sel)
         tmhq_pkg::RD_LAST: begin
            ra_addr = IW'(len_dec);
            rb_addr = IW'(len_dec);
         end
         tmhq_pkg::RD_CHILD: begin
            ra_addr = l_ok ? l_idx[IW-1:0] : '0;
            rb_addr = r_ok ? r_idx[IW-1:0] : '0;
         end
         tmhq_pkg::RD_PARENT: begin
            ra_addr = p_idx;
            rb_addr = p_idx;
         end
         default: begin
            ra_addr = '0;
            rb_addr = '0;
         end
      endcase
   end

   // slot and position writes
   logic                 wr_en, pw_en;
   logic [IW-1:0]        wr_addr, wr_id;
   logic [TIME_BITS-1:0] wr_due;
   logic                 do_place;

   assign do_place = cmd.place || (cmd.sd_cmp && !sd_move && (s_ff != start_ff))
                     || (cmd.su_cmp && su_stop);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s_ff;
      wr_id   = cid_ff;
      wr_due  = cdue_ff;
      if (do_place) begin
         wr_en = 1'b1;
      end else if (cmd.sd_cmp && sd_move) begin
         wr_en  = 1'b1;
         wr_id  = take_r ? rdb_id_ff : rda_id_ff;
         wr_due = take_r ? rdb_due_ff : rda_due_ff;
      end else if (cmd.su_cmp) begin
         wr_en  = 1'b1;
         wr_id  = rda_id_ff;
         wr_due = rda_due_ff;
      end
      pw_en = wr_en;
   end

   // memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]  <= wr_id;
         due_mem[wr_addr] <= wr_due;
      end
      if (pw_en) begin
         pos_mem[wr_id] <= PW'(wr_addr);
      end
      rda_id_ff  <= id_mem[ra_addr];
      rda_due_ff <= due_mem[ra_addr];
      rdb_id_ff  <= id_mem[rb_addr];
      rdb_due_ff <= due_mem[rb_addr];
      pos_rd_ff  <= pos_mem[req_id];
   end

   // position valid bits: clear means idle
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_vld_ff <= '0;
      end else begin
         if (cmd.clear_req) begin
            pos_vld_ff[req_id] <= 1'b0;
         end
         if (cmd.pop_go) begin
            pos_vld_ff[top_id_ff] <= 1'b0;
         end
         if (pw_en) begin
            pos_vld_ff[wr_id] <= 1'b1;
         end
      end
   end

   // heap length
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (cmd.cancel_go || cmd.pop_go) begin
         len_ff <= len_dec;
      end else if (cmd.append && !status.full) begin
         len_ff <= len_ff + PW'(1);
      end
   end

   // request, carried element and sift position
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.cancel_go) begin
         s_ff     <= IW'(pos_rd_ff);
         start_ff <= IW'(pos_rd_ff);
      end else if (cmd.pop_go) begin
         s_ff     <= '0;
         start_ff <= '0;
         fired_ff <= top_id_ff;
      end else if (cmd.append) begin
         s_ff    <= IW'(len_ff);
         cid_ff  <= req_id;
         cdue_ff <= due_new;
      end else if (cmd.sd_cmp && sd_move) begin
         s_ff <= take_r ? r_idx[IW-1:0] : l_idx[IW-1:0];
      end else if (cmd.su_cmp && !su_stop) begin
         s_ff <= p_idx;
      end
      if (cmd.load_carried) begin
         cid_ff  <= rda_id_ff;
         cdue_ff <= rda_due_ff;
      end
      // shadow of slot zero
      if (wr_en && (wr_addr == '0)) begin
         top_id_ff  <= wr_id;
         top_due_ff <= wr_due;
      end
   end

   // status
   always_comb begin
      status            = '0;
      status.op_arm     = (req_ff.opcode == tmhq_pkg::OP_ARM);
      status.op_cancel  = (req_ff.opcode == tmhq_pkg::OP_CANCEL);
      status.op_poll    = (req_ff.opcode == tmhq_pkg::OP_POLL);
      status.id_ok      = 7'(req_ff.timer_id) < 7'(NUM_TIMERS);
      status.pos_armed  = pos_vld_ff[req_id] && (pos_rd_ff < len_ff);
      status.hole_last  = (pos_rd_ff == len_dec);
      status.pop_due    = (len_ff != '0) && (top_due_ff <= now_t);
      status.pop_last   = (len_ff == PW'(1));
      status.sd_move    = sd_move;
      status.s_at_start = (s_ff == start_ff);
      status.s_zero     = (s_ff == '0);
      status.su_stop    = su_stop;
      status.full       = (len_ff >= PW'(NUM_TIMERS));
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_fire || cmd.emit_done;
      end
      rsp_ff.fired_valid  <= cmd.emit_fire;
      rsp_ff.fired_timer  <= cmd.emit_fire ? 5'(fired_ff) : 5'd0;
      rsp_ff.earliest_due <= (len_ff != '0) ? 48'(top_due_ff) : 48'd0;
      rsp_ff.heap_empty   <= (len_ff == '0);
      rsp_ff.armed_count  <= 6'(len_ff);
      rsp_ff.last_of_run  <= cmd.emit_done;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/timer_min_heap_queue.sv =====
// ---------------------------------------------------------------------------
// timer_min_heap_queue
// Indexed binary min-heap of armed timers keyed on due time, with arm,
// cancel and poll requests and a per-timer heap position.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every response is
// shown for one cycle with rsp_valid and cannot be held off, so the receiver
// must take it in that cycle. Arm and cancel give one status response; poll
// gives one response per fired timer, then a status response with
// last_of_run set. Each sift level passes through a read state and a compare
// state, since the read of the slot memory is registered. A cancel of an
// armed timer that is not in the last slot refills the hole with the last
// element, which sinks or else climbs; an arm first cancels any earlier
// arming of its timer, then, unless the heap is full, appends the new timer,
// which climbs. A poll fires each due timer at the top; unless that empties
// the heap, the last element refills the top and sinks. Each response is
// registered and comes out in the cycle after its strobe state. No clearing
// pass is needed after reset.
module timer_min_heap_queue #(
   parameter int NUM_TIMERS = 32,
   parameter int TIME_BITS  = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tmhq_pkg::req_type req_data,
   output logic              rsp_valid,
   output tmhq_pkg::rsp_type rsp_data
);

   tmhq_pkg::cmd_type    cmd;
   tmhq_pkg::status_type status;

   // sequencer
   tmhq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // heap storage and arithmetic
   tmhq_dpath #(
      .NUM_TIMERS (NUM_TIMERS),
      .TIME_BITS  (TIME_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
